>>> rtl/slt_pkg.sv
// slt_pkg: shared types and codes for the sorted list table.
// Holds the command and status codes, the entry type and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

    // Entry value as stored and compared
    typedef logic signed [31:0] value_t;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Field widths on the stream ports
    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int OUT_W   = 16;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // Strobes broadcast from the controller to every cell
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sorted_list_table.sv
// sorted_list_table: bounded ascending multiset of signed 32-bit values in a chain of cells.
// Instantiates slt_ctrl and CAPACITY copies of slt_cell; depends on slt_pkg.
//
//  channel | signals                     | content (low bit first)
//  --------+-----------------------------+----------------------------------------
//  s       | s_tvalid s_tready s_tdata   | tdata: value[31:0]; tuser: cmd[1:0]
//          | s_tuser                     |
//  m       | m_tvalid m_tready m_tdata   | tdata: found, status[1:0], entry_count[6:0]
//
// Each request has an acceptance cycle, in which every cell compares its entry with the
// value, and then an apply cycle, in which the cells shift as one step.
// The apply cycle waits while the result register is full and not taken; a new request
// is accepted while a finished result waits. Reset clears the count and the cell flags;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [slt_pkg::VALUE_W-1:0]    s_tdata,   // value[31:0]
    input  wire logic [slt_pkg::CMD_W-1:0]      s_tuser,   // cmd[1:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [slt_pkg::OUT_W-1:0]           m_tdata    // found, status[1:0], count[6:0]
);
    import slt_pkg::*;

    cell_ctl_t ctl;
    value_t    ins_value;
    value_t    cmp_value;
    value_t    entry_w [CAPACITY];
    logic      valid_w [CAPACITY];
    logic      after_w [CAPACITY];
    logic [CAPACITY-1:0] eq_w;
    logic      hit;

    assign cmp_value = s_tdata;
    assign hit       = |eq_w;

    slt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .hit       (hit),
        .ctl       (ctl),
        .ins_value (ins_value),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Chain of cells, lowest entry first
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        value_t left_entry;
        logic   left_valid;
        logic   left_after;
        value_t right_entry;
        logic   right_valid;

        if (i == 0)
        begin : g_head
            assign left_entry = ins_value;
            assign left_valid = 1'b1;
            assign left_after = 1'b0;
        end
        else
        begin : g_mid_l
            assign left_entry = entry_w[i-1];
            assign left_valid = valid_w[i-1];
            assign left_after = after_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = ins_value;
            assign right_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_entry = entry_w[i+1];
            assign right_valid = valid_w[i+1];
        end

        slt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cmp_value   (cmp_value),
            .ins_value   (ins_value),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .left_after  (left_after),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .entry       (entry_w[i]),
            .valid       (valid_w[i]),
            .after       (after_w[i]),
            .eq          (eq_w[i])
        );
    end

endmodule

`default_nettype wire

>>> rtl/slt_cell.sv
// slt_cell: one slot of the ordered chain.
// Holds one entry, compares it with the request value and shifts with its neighbors.
// Depends on slt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slt_cell (
    input  wire                logic        clk,
    input  wire                logic        rst_n,
    input  wire slt_pkg::cell_ctl_t         ctl,
    input  wire slt_pkg::value_t            cmp_value,
    input  wire slt_pkg::value_t            ins_value,
    input  wire slt_pkg::value_t            left_entry,
    input  wire                logic        left_valid,
    input  wire                logic        left_after,
    input  wire slt_pkg::value_t            right_entry,
    input  wire                logic        right_valid,
    output slt_pkg::value_t                 entry,
    output logic                            valid,
    output logic                            after,
    output logic                            eq
);
    import slt_pkg::*;

    value_t entry_reg, entry_next;
    logic   valid_reg, valid_next;
    logic   after_reg, after_next;
    logic   eq_reg, eq_next;

    // Compare, then insert with right shift or remove with left shift
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        after_next = after_reg;
        eq_next    = eq_reg;
        if (ctl.cmp_en)
        begin
            after_next = !valid_reg || (entry_reg >= cmp_value);
            eq_next    = valid_reg && (entry_reg == cmp_value);
        end
        if (ctl.ins_en && after_reg)
        begin
            entry_next = left_after ? left_entry : ins_value;
            valid_next = valid_reg | left_valid;
        end
        if (ctl.rem_en && after_reg)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            after_reg <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            after_reg <= after_next;
            eq_reg    <= eq_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign after = after_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

>>> rtl/slt_ctrl.sv
// slt_ctrl: request sequencer, entry count and result register of the sorted list table.
// Drives the cell strobes and packs the result onto the output stream.
// Depends on slt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slt_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [slt_pkg::CMD_W-1:0]      s_tuser,
    input  wire logic [slt_pkg::VALUE_W-1:0]    s_tdata,
    input  wire logic                           hit,
    output slt_pkg::cell_ctl_t                  ctl,
    output slt_pkg::value_t                     ins_value,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [slt_pkg::OUT_W-1:0]           m_tdata
);
    import slt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    value_t            value_reg, value_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    logic              accept;
    logic              out_free;
    logic              apply;
    logic              full;
    logic              empty;
    logic              found_d;
    logic [1:0]        status_d;
    logic              ins_d;
    logic              rem_d;
    logic [CW+6:0]     count_ext;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready = 1'b0;
        apply    = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_APPLY: apply    = out_free;
            default:  s_tready = 1'b0;
        endcase
    end

    // Decode the held request against the compare results
    always_comb
    begin
        found_d  = 1'b0;
        status_d = STATUS_OK;
        ins_d    = 1'b0;
        rem_d    = 1'b0;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (full)
                    status_d = STATUS_FULL;
                else
                    ins_d = 1'b1;
            end
            CMD_SEARCH:
            begin
                if (empty)
                    status_d = STATUS_EMPTY;
                else
                    found_d = hit;
            end
            CMD_REMOVE:
            begin
                if (empty)
                    status_d = STATUS_EMPTY;
                else
                begin
                    found_d = hit;
                    rem_d   = hit;
                end
            end
            default: found_d = 1'b0;
        endcase
    end

    // Count, request hold and result register
    always_comb
    begin
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        if (accept)
        begin
            cmd_next   = s_tuser;
            value_next = s_tdata;
        end
        if (apply)
        begin
            if (ins_d)
                count_next = count_reg + CW'(1);
            else if (rem_d)
                count_next = count_reg - CW'(1);
            m_tvalid_next = 1'b1;
        end
        count_ext = (CW + 7)'(count_next);
        if (apply)
            m_tdata_next = {{(OUT_W - COUNT_W - 3){1'b0}}, count_ext[COUNT_W-1:0],
                            status_d, found_d};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        value_reg   <= value_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Compare at acceptance, shift on the apply cycle
    assign ctl.cmp_en = accept;
    assign ctl.ins_en = apply && ins_d;
    assign ctl.rem_en = apply && rem_d;
    assign ins_value  = value_reg;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/slt_checker.sv
// slt_checker: port-level checks on the sorted list table, with its bind statement.
// Depends on slt_pkg and binds to sorted_list_table.
`timescale 1ns / 1ps
`default_nettype none

module slt_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [slt_pkg::OUT_W-1:0]      m_tdata
);
    import slt_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request in flight: no acceptance right after an acceptance
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // Status code is always defined
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:1] == STATUS_OK || m_tdata[2:1] == STATUS_FULL ||
                     m_tdata[2:1] == STATUS_EMPTY)
        else $error("undefined status code");

    // A hit only comes with status ok
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == STATUS_OK)
        else $error("found flag with non-ok status");

    // Count never exceeds capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CAPACITY > 127) || (int'(m_tdata[9:3]) <= CAPACITY))
        else $error("entry count above capacity");

endmodule

bind sorted_list_table slt_checker #(
    .CAPACITY (CAPACITY)
) u_slt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
